### sv/swcd_pkg.sv
// Package with the shared types and constants of the stopwatch and countdown timer.
`timescale 1ns / 1ps
package swcd_pkg;

  // Largest count of whole seconds that the display can show (99:59:59).
  localparam int unsigned MAX_SHOWN_SECONDS = 359999;
  localparam int SEC_W       = 19;
  localparam int TPS_DEFAULT = 60;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMER_MODE   = 1'b0,
    CFG_EXIT_ON_ZERO = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    TM_COUNT_UP    = 2'd0,
    TM_COUNT_DOWN  = 2'd1,
    TM_TIME_OF_DAY = 2'd2
  } timer_mode_t;

  typedef struct packed {
    logic [1:0] timer_mode;
    logic       exit_on_zero;
  } cfg_t;

  // Count after one word has been applied, as whole seconds plus a flag for
  // a part second, together with the finished flag of that word.
  typedef struct packed {
    logic [SEC_W-1:0] sec;
    logic             sub_nz;
    logic             finished;
  } entry_t;

endpackage

### sv/swcd_count.sv
// Time count register with the load, count up, count down and clock copy rules.
`timescale 1ns / 1ps
module swcd_count #(
  parameter int TICKS_PER_SECOND = swcd_pkg::TPS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  swcd_pkg::cfg_t           cfg,
  input  logic                     command,
  input  logic [18:0]              load_seconds,
  input  logic [16:0]              clock_seconds,
  input  logic                     hold,
  output swcd_pkg::entry_t         entry
);
  import swcd_pkg::*;

  localparam int SUB_W     = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
  localparam int LIM_TICKS = int'(MAX_SHOWN_SECONDS) * TICKS_PER_SECOND + 1;
  localparam int LIM_SEC   = LIM_TICKS / TICKS_PER_SECOND;
  localparam int LIM_SUB   = LIM_TICKS % TICKS_PER_SECOND;

  logic [SEC_W-1:0] sec_r, sec_nxt;
  logic [SUB_W-1:0] sub_r, sub_nxt;
  logic             fin;
  logic             at_limit;
  logic             sub_top;
  logic [SEC_W-1:0] load_clamped;

  // The count is held as whole seconds and a tick within the second, so the
  // display never needs a division by the tick rate.
  assign at_limit = (sec_r == SEC_W'(LIM_SEC)) && (sub_r == SUB_W'(LIM_SUB));
  assign sub_top  = (sub_r == SUB_W'(TICKS_PER_SECOND - 1));
  assign load_clamped = (load_seconds > 19'(MAX_SHOWN_SECONDS)) ?
                        SEC_W'(MAX_SHOWN_SECONDS) : load_seconds;

  always_comb begin
    sec_nxt = sec_r;
    sub_nxt = sub_r;
    fin     = 1'b0;
    if (command) begin
      sec_nxt = load_clamped;
      sub_nxt = '0;
    end else if (!hold) begin
      unique case (cfg.timer_mode)
        TM_COUNT_UP: begin
          if (!at_limit) begin
            if (sub_top) begin
              sec_nxt = sec_r + SEC_W'(1);
              sub_nxt = '0;
            end else begin
              sub_nxt = sub_r + SUB_W'(1);
            end
          end
        end
        TM_COUNT_DOWN: begin
          if ((sec_r == '0) && (sub_r == '0)) begin
            fin = cfg.exit_on_zero;
          end else if (sub_r == '0) begin
            sec_nxt = sec_r - SEC_W'(1);
            sub_nxt = SUB_W'(TICKS_PER_SECOND - 1);
          end else begin
            sub_nxt = sub_r - SUB_W'(1);
          end
        end
        TM_TIME_OF_DAY: begin
          // A 17-bit time of day is always within the display range.
          sec_nxt = SEC_W'(clock_seconds);
          sub_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r <= '0;
      sub_r <= '0;
    end else if (accept) begin
      sec_r <= sec_nxt;
      sub_r <= sub_nxt;
    end
  end

  assign entry.sec      = sec_nxt;
  assign entry.sub_nz   = (sub_nxt != '0);
  assign entry.finished = fin;

endmodule

### sv/swcd_hms_pipe.sv
// Pipeline that turns the count into six HH:MM:SS digits, with per-stage flow control.
`timescale 1ns / 1ps
module swcd_hms_pipe (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  swcd_pkg::entry_t in_entry,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [3:0]       hours_tens,
  output logic [3:0]       hours_units,
  output logic [2:0]       minutes_tens,
  output logic [3:0]       minutes_units,
  output logic [2:0]       seconds_tens,
  output logic [3:0]       seconds_units,
  output logic             finished
);
  import swcd_pkg::*;

  localparam int NSTG = 7;
  // floor(s / 3600) = (s * HR_MUL) >> 30 and floor(r / 60) = (r * MN_MUL) >> 18
  // hold exactly over the ranges met here.
  localparam logic [18:0] HR_MUL = 19'd298262;
  localparam logic [12:0] MN_MUL = 13'd4370;

  // Tens digit of a value below 100, as a count of the decades it passes.
  function automatic logic [3:0] tens_of(input logic [6:0] x);
    logic [3:0] t;
    t = '0;
    for (int k = 1; k <= 9; k++) begin
      t = t + 4'(x >= 7'(10 * k));
    end
    return t;
  endfunction

  logic [NSTG-1:0] v_r;
  logic [NSTG:0]   rdy;

  always_comb begin
    rdy[NSTG] = out_ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Stage 1: the count as captured.
  entry_t           p1_r;
  // Stage 2: seconds rounded up and clamped.
  logic [SEC_W-1:0] p2_s_r, p2_s_nxt;
  logic [SEC_W:0]   p2_sum;
  logic             p2_fin_r;
  // Stage 3: hours.
  logic [SEC_W-1:0] p3_s_r;
  logic [6:0]       p3_h_r, p3_h_nxt;
  logic [37:0]      p3_prod;
  logic             p3_fin_r;
  // Stage 4: seconds within the hour.
  logic [11:0]      p4_rem_r, p4_rem_nxt;
  logic [SEC_W-1:0] p4_diff;
  logic [6:0]       p4_h_r;
  logic             p4_fin_r;
  // Stage 5: minutes.
  logic [11:0]      p5_rem_r;
  logic [5:0]       p5_m_r, p5_m_nxt;
  logic [24:0]      p5_prod;
  logic [6:0]       p5_h_r;
  logic             p5_fin_r;
  // Stage 6: seconds within the minute.
  logic [5:0]       p6_sec_r, p6_sec_nxt;
  logic [11:0]      p6_diff;
  logic [5:0]       p6_m_r;
  logic [6:0]       p6_h_r;
  logic             p6_fin_r;
  // Stage 7: output digits.
  logic [3:0]       ht_nxt, mt_nxt, st_nxt;
  logic [3:0]       ht_r, hu_r, mu_r, su_r;
  logic [2:0]       mt_r, st_r;
  logic             fin_r;

  assign p2_sum   = {1'b0, p1_r.sec} + (SEC_W + 1)'(p1_r.sub_nz);
  assign p2_s_nxt = (p2_sum > (SEC_W + 1)'(MAX_SHOWN_SECONDS)) ?
                    SEC_W'(MAX_SHOWN_SECONDS) : p2_sum[SEC_W-1:0];

  assign p3_prod  = 38'(p2_s_r) * 38'(HR_MUL);
  assign p3_h_nxt = p3_prod[36:30];

  assign p4_diff    = p3_s_r - (SEC_W'(p3_h_r) * SEC_W'(3600));
  assign p4_rem_nxt = p4_diff[11:0];

  assign p5_prod  = 25'(p4_rem_r) * 25'(MN_MUL);
  assign p5_m_nxt = p5_prod[23:18];

  assign p6_diff    = p5_rem_r - (12'(p5_m_r) * 12'd60);
  assign p6_sec_nxt = p6_diff[5:0];

  assign ht_nxt = tens_of(p6_h_r);
  assign mt_nxt = tens_of({1'b0, p6_m_r});
  assign st_nxt = tens_of({1'b0, p6_sec_r});

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      p1_r <= in_entry;
    end
    if (rdy[1]) begin
      p2_s_r   <= p2_s_nxt;
      p2_fin_r <= p1_r.finished;
    end
    if (rdy[2]) begin
      p3_s_r   <= p2_s_r;
      p3_h_r   <= p3_h_nxt;
      p3_fin_r <= p2_fin_r;
    end
    if (rdy[3]) begin
      p4_rem_r <= p4_rem_nxt;
      p4_h_r   <= p3_h_r;
      p4_fin_r <= p3_fin_r;
    end
    if (rdy[4]) begin
      p5_rem_r <= p4_rem_r;
      p5_m_r   <= p5_m_nxt;
      p5_h_r   <= p4_h_r;
      p5_fin_r <= p4_fin_r;
    end
    if (rdy[5]) begin
      p6_sec_r <= p6_sec_nxt;
      p6_m_r   <= p5_m_r;
      p6_h_r   <= p5_h_r;
      p6_fin_r <= p5_fin_r;
    end
    if (rdy[6]) begin
      ht_r  <= ht_nxt;
      hu_r  <= 4'(p6_h_r - 7'(ht_nxt) * 7'd10);
      mt_r  <= mt_nxt[2:0];
      mu_r  <= 4'(p6_m_r - 6'(mt_nxt) * 6'd10);
      st_r  <= st_nxt[2:0];
      su_r  <= 4'(p6_sec_r - 6'(st_nxt) * 6'd10);
      fin_r <= p6_fin_r;
    end
  end

  assign in_ready      = rdy[0];
  assign out_valid     = v_r[NSTG-1];
  assign hours_tens    = ht_r;
  assign hours_units   = hu_r;
  assign minutes_tens  = mt_r;
  assign minutes_units = mu_r;
  assign seconds_tens  = st_r;
  assign seconds_units = su_r;
  assign finished      = fin_r;

endmodule

### sv/stopwatch_countdown_hms_timer_core.sv
// Top level of the stopwatch, countdown and clock timer with an HH:MM:SS result.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_ready   command, load_seconds, clock_seconds, hold
//   out_     output     out_valid/out_ready six display digits, finished
//   cfg_     input      cfg_we              cfg_index, cfg_wdata
//
// One word is taken every cycle while in_ready is high; its result is offered once
// it has passed the seven digit conversion stages, the first loaded by the accepting edge.
// A stage moves on unless it is full and the stage after it is stalled, so
// words keep entering while a result waits, until all seven stages are full.
// Reset clears the count, both configuration registers and all stage valids.
`timescale 1ns / 1ps
module stopwatch_countdown_hms_timer_core #(
  parameter int TICKS_PER_SECOND = swcd_pkg::TPS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_command,
  input  logic [18:0]                    in_load_seconds,
  input  logic [16:0]                    in_clock_seconds,
  input  logic                           in_hold,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [3:0]                     out_hours_tens,
  output logic [3:0]                     out_hours_units,
  output logic [2:0]                     out_minutes_tens,
  output logic [3:0]                     out_minutes_units,
  output logic [2:0]                     out_seconds_tens,
  output logic [3:0]                     out_seconds_units,
  output logic                           out_finished,
  input  logic                           cfg_we,
  input  logic [swcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swcd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import swcd_pkg::*;

  cfg_t   cfg_r;
  entry_t entry;
  logic   accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIMER_MODE:   cfg_r.timer_mode   <= cfg_wdata[1:0];
        CFG_EXIT_ON_ZERO: cfg_r.exit_on_zero <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign accept = in_valid && in_ready;

  swcd_count #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_count (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .cfg          (cfg_r),
    .command      (in_command),
    .load_seconds (in_load_seconds),
    .clock_seconds(in_clock_seconds),
    .hold         (in_hold),
    .entry        (entry)
  );

  swcd_hms_pipe u_pipe (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_entry     (entry),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hours_tens   (out_hours_tens),
    .hours_units  (out_hours_units),
    .minutes_tens (out_minutes_tens),
    .minutes_units(out_minutes_units),
    .seconds_tens (out_seconds_tens),
    .seconds_units(out_seconds_units),
    .finished     (out_finished)
  );

endmodule

### sv/swcd_checker.sv
// Port-level checks for the timer top level, bound to it below.
`timescale 1ns / 1ps
module swcd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           in_command,
  input logic [18:0]                    in_load_seconds,
  input logic [16:0]                    in_clock_seconds,
  input logic                           in_hold,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [3:0]                     out_hours_tens,
  input logic [3:0]                     out_hours_units,
  input logic [2:0]                     out_minutes_tens,
  input logic [3:0]                     out_minutes_units,
  input logic [2:0]                     out_seconds_tens,
  input logic [3:0]                     out_seconds_units,
  input logic                           out_finished
);

  // A word waiting at the input keeps its payload until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_command) &&
      $stable(in_load_seconds) && $stable(in_clock_seconds) && $stable(in_hold))
    else $error("input word changed while waiting");

  // A word waiting at the output stays put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hours_tens) &&
      $stable(out_hours_units) && $stable(out_minutes_tens) &&
      $stable(out_minutes_units) && $stable(out_seconds_tens) &&
      $stable(out_seconds_units) && $stable(out_finished))
    else $error("output word changed while stalled");

  // Reset empties the whole pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // Finished is only raised by a countdown resting at zero.
  a_finished_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finished |-> out_hours_tens == 4'd0 && out_hours_units == 4'd0 &&
      out_minutes_tens == 3'd0 && out_minutes_units == 4'd0 &&
      out_seconds_tens == 3'd0 && out_seconds_units == 4'd0)
    else $error("finished with a non-zero display");

  // Every digit the conversion produces is a decimal digit in its range.
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hours_tens <= 4'd9 && out_hours_units <= 4'd9 &&
      out_minutes_tens <= 3'd5 && out_minutes_units <= 4'd9 &&
      out_seconds_tens <= 3'd5 && out_seconds_units <= 4'd9)
    else $error("display digit out of range");

endmodule

bind stopwatch_countdown_hms_timer_core swcd_checker u_swcd_checker (.*);

### tb/sv/tb_stopwatch_countdown_hms_timer_core.sv
// Self-checking testbench for the stopwatch, countdown and clock timer core.
`timescale 1ns / 1ps
module tb_stopwatch_countdown_hms_timer_core;
  import swcd_pkg::*;

  localparam int          TPS          = TPS_DEFAULT;
  localparam int unsigned TICK_CEILING = MAX_SHOWN_SECONDS * TPS + 1;
  localparam logic [1:0]  MODE_UNUSED  = 2'd3;
  localparam logic        CMD_TICK     = 1'b0;
  localparam logic        CMD_LOAD     = 1'b1;
  // Pipeline depth plus a margin, waited out before a register write and at the end.
  localparam int          SETTLE_CYCLES = 12;
  localparam int          REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [3:0] hours_tens;
    logic [3:0] hours_units;
    logic [2:0] minutes_tens;
    logic [3:0] minutes_units;
    logic [2:0] seconds_tens;
    logic [3:0] seconds_units;
    logic       finished;
  } hms_display_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_command;
  logic [18:0] in_load_seconds;
  logic [16:0] in_clock_seconds;
  logic        in_hold;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  out_hours_tens;
  logic [3:0]  out_hours_units;
  logic [2:0]  out_minutes_tens;
  logic [3:0]  out_minutes_units;
  logic [2:0]  out_seconds_tens;
  logic [3:0]  out_seconds_units;
  logic        out_finished;
  logic        cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Predictor state: the tick count and its own copy of both registers.
  logic [24:0] model_ticks;
  logic [1:0]  model_mode;
  logic        model_exit_on_zero;

  hms_display_t pending_displays[$];
  int unsigned  fault_count;
  int unsigned  words_sent;
  int unsigned  displays_checked;
  int unsigned  finished_seen;
  int unsigned  reg_writes;
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;

  stopwatch_countdown_hms_timer_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_load_seconds   (in_load_seconds),
    .in_clock_seconds  (in_clock_seconds),
    .in_hold           (in_hold),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hours_tens    (out_hours_tens),
    .out_hours_units   (out_hours_units),
    .out_minutes_tens  (out_minutes_tens),
    .out_minutes_units (out_minutes_units),
    .out_seconds_tens  (out_seconds_tens),
    .out_seconds_units (out_seconds_units),
    .out_finished      (out_finished),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[stopwatch_countdown_hms_timer_core] ERROR");
    $finish;
  end

  function automatic logic [24:0] seconds_as_ticks(input logic [18:0] secs);
    longint unsigned s;
    s = secs;
    if (s > MAX_SHOWN_SECONDS) s = MAX_SHOWN_SECONDS;
    return 25'(s * TPS);
  endfunction

  // Applies one word to the predicted count and returns the display it should produce.
  function automatic hms_display_t advance_timer(input logic cmd, input logic [18:0] load_s,
                                                 input logic [16:0] clock_s, input logic hold);
    hms_display_t    shown;
    longint unsigned secs, hrs, mins, rem;
    shown = '0;
    if (cmd == CMD_LOAD) begin
      model_ticks = seconds_as_ticks(load_s);
    end else if (!hold) begin
      case (model_mode)
        TM_COUNT_UP: begin
          if (model_ticks < TICK_CEILING) model_ticks = model_ticks + 1'b1;
          else model_ticks = 25'(TICK_CEILING);
        end
        TM_COUNT_DOWN: begin
          if (model_ticks != 0) model_ticks = model_ticks - 1'b1;
          else shown.finished = model_exit_on_zero;
        end
        TM_TIME_OF_DAY: model_ticks = seconds_as_ticks({2'b00, clock_s});
        default: ;
      endcase
    end
    // A part second rounds the shown time up.
    secs = model_ticks / TPS + ((model_ticks % TPS) != 0 ? 1 : 0);
    if (secs > MAX_SHOWN_SECONDS) secs = MAX_SHOWN_SECONDS;
    hrs  = secs / 3600;
    rem  = secs % 3600;
    mins = rem / 60;
    rem  = rem % 60;
    shown.hours_tens    = 4'(hrs / 10);
    shown.hours_units   = 4'(hrs % 10);
    shown.minutes_tens  = 3'(mins / 10);
    shown.minutes_units = 4'(mins % 10);
    shown.seconds_tens  = 3'(rem / 10);
    shown.seconds_units = 4'(rem % 10);
    return shown;
  endfunction

  // Result side: random stalls, and each accepted word is checked against the oldest prediction.
  always @(posedge clk) begin
    hms_display_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_hours_tens, out_hours_units, out_minutes_tens, out_minutes_units,
              out_seconds_tens, out_seconds_units, out_finished};
      if (pending_displays.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
          $display("unexpected result word %0d%0d:%0d%0d:%0d%0d finished %0b",
                   got.hours_tens, got.hours_units, got.minutes_tens, got.minutes_units,
                   got.seconds_tens, got.seconds_units, got.finished);
      end else begin
        want = pending_displays.pop_front();
        displays_checked++;
        if (want.finished) finished_seen++;
        if (got !== want) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT)
            $display("mismatch %0d: want %0d%0d:%0d%0d:%0d%0d f%0b, got %0d%0d:%0d%0d:%0d%0d f%0b",
                     displays_checked,
                     want.hours_tens, want.hours_units, want.minutes_tens, want.minutes_units,
                     want.seconds_tens, want.seconds_units, want.finished,
                     got.hours_tens, got.hours_units, got.minutes_tens, got.minutes_units,
                     got.seconds_tens, got.seconds_units, got.finished);
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_word(input logic cmd, input logic [18:0] load_s,
                           input logic [16:0] clock_s, input logic hold);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_load_seconds  <= load_s;
    in_clock_seconds <= clock_s;
    in_hold          <= hold;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_displays.push_back(advance_timer(cmd, load_s, clock_s, hold));
    words_sent++;
  endtask

  // Stops sending and waits until every predicted word has come back.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_displays.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_timer_reg(input cfg_index_t idx, input logic [1:0] value);
    drain_pipeline();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TIMER_MODE) model_mode = value;
    else model_exit_on_zero = value[0];
    reg_writes++;
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  function automatic logic [16:0] pick_clock();
    logic [16:0] raw;
    raw = 17'($urandom);
    if ($urandom_range(1)) return 17'($urandom_range(0, 86399));
    return raw;
  endfunction

  // Loads are biased so that tick runs reach the interesting ends of the count-up and countdown modes.
  function automatic logic [18:0] pick_load();
    logic [18:0] raw;
    raw = 19'($urandom);
    case ($urandom_range(4))
      0: return raw;
      1: return 19'($urandom_range(0, MAX_SHOWN_SECONDS));
      default: begin
        if (model_mode == TM_COUNT_DOWN) return 19'($urandom_range(0, 2));
        if (model_mode == TM_COUNT_UP)
          return 19'($urandom_range(MAX_SHOWN_SECONDS - 2, MAX_SHOWN_SECONDS));
        return raw;
      end
    endcase
  endfunction

  // Mostly a load followed by a run of ticks, with some fully random words mixed in.
  task automatic run_traffic(input int unsigned n_words);
    int unsigned sent, run_len;
    logic [18:0] raw_load;
    logic [16:0] raw_clock;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(99) < 70) begin
        send_word(CMD_LOAD, pick_load(), pick_clock(), 1'($urandom_range(1)));
        run_len = $urandom_range(1, 120);
        if (run_len > n_words - sent - 1) run_len = n_words - sent - 1;
        repeat (run_len) begin
          raw_load = 19'($urandom);
          send_word(CMD_TICK, raw_load, pick_clock(), $urandom_range(99) < 10);
        end
        sent += run_len + 1;
      end else begin
        raw_load  = 19'($urandom);
        raw_clock = 17'($urandom);
        send_word(1'($urandom_range(1)), raw_load, raw_clock, 1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  task automatic test_stopwatch_limits();
    write_timer_reg(CFG_TIMER_MODE, TM_COUNT_UP);
    write_timer_reg(CFG_EXIT_ON_ZERO, 2'd0);
    send_word(CMD_LOAD, 19'd0, 17'd0, 1'b0);
    send_word(CMD_TICK, 19'd0, 17'd0, 1'b0);
    send_word(CMD_TICK, 19'd0, 17'd0, 1'b1);
    send_word(CMD_LOAD, 19'(MAX_SHOWN_SECONDS), 17'h1FFFF, 1'b1);
    // One tick past the top of the display, then held there.
    send_word(CMD_TICK, 19'h7FFFF, 17'h1FFFF, 1'b0);
    send_word(CMD_TICK, 19'h7FFFF, 17'h1FFFF, 1'b0);
    send_word(CMD_LOAD, 19'h7FFFF, 17'd0, 1'b0);
  endtask

  task automatic test_countdown_zero();
    write_timer_reg(CFG_TIMER_MODE, TM_COUNT_DOWN);
    write_timer_reg(CFG_EXIT_ON_ZERO, 2'd1);
    send_word(CMD_LOAD, 19'd1, 17'd0, 1'b0);
    send_word(CMD_TICK, 19'd0, 17'd0, 1'b0);
    send_word(CMD_LOAD, 19'd0, 17'd0, 1'b0);
    send_word(CMD_TICK, 19'd0, 17'd0, 1'b0);
    send_word(CMD_TICK, 19'd0, 17'd0, 1'b1);
    write_timer_reg(CFG_EXIT_ON_ZERO, 2'd0);
    send_word(CMD_TICK, 19'd0, 17'd0, 1'b0);
  endtask

  task automatic test_clock_copy();
    write_timer_reg(CFG_TIMER_MODE, TM_TIME_OF_DAY);
    send_word(CMD_TICK, 19'd0, 17'd0, 1'b0);
    send_word(CMD_TICK, 19'd0, 17'd86399, 1'b0);
    send_word(CMD_TICK, 19'd0, 17'h1FFFF, 1'b0);
    send_word(CMD_TICK, 19'd0, 17'd5, 1'b1);
    send_word(CMD_LOAD, 19'd7, 17'd9, 1'b1);
  endtask

  task automatic test_unused_mode();
    write_timer_reg(CFG_TIMER_MODE, MODE_UNUSED);
    write_timer_reg(CFG_EXIT_ON_ZERO, 2'd1);
    send_word(CMD_LOAD, 19'd100, 17'd0, 1'b0);
    send_word(CMD_TICK, 19'd0, 17'd300, 1'b0);
    send_word(CMD_TICK, 19'd0, 17'd300, 1'b1);
  endtask

  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                     input logic [1:0] mode, input logic exit_flag,
                                     input int unsigned n_words);
    write_timer_reg(CFG_TIMER_MODE, mode);
    write_timer_reg(CFG_EXIT_ON_ZERO, {1'b0, exit_flag});
    set_idling(send_pct, recv_pct);
    run_traffic(n_words);
  endtask

  // The sender stops mid-stream until the whole pipeline has emptied, then carries on.
  task automatic test_drain_pause();
    write_timer_reg(CFG_TIMER_MODE, 2'($urandom_range(2)));
    set_idling(10, 10);
    run_traffic(40);
    drain_pipeline();
    run_traffic(40);
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_command       <= CMD_TICK;
    in_load_seconds  <= '0;
    in_clock_seconds <= '0;
    in_hold          <= 1'b0;
    out_ready        <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_TIMER_MODE;
    cfg_wdata        <= '0;
    model_ticks        = '0;
    model_mode         = TM_COUNT_UP;
    model_exit_on_zero = 1'b0;
    fault_count      = 0;
    words_sent       = 0;
    displays_checked = 0;
    finished_seen    = 0;
    reg_writes       = 0;
    set_idling(0, 0);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_stopwatch_limits();
    test_countdown_zero();
    test_clock_copy();
    test_unused_mode();
    test_random_traffic(0, 0, TM_COUNT_UP, 1'b0, 150);
    test_random_traffic(59, 0, TM_COUNT_DOWN, 1'b1, 150);
    test_random_traffic(0, 59, TM_TIME_OF_DAY, 1'b0, 150);
    test_random_traffic(10, 10, TM_COUNT_DOWN, 1'b0, 120);
    test_random_traffic(59, 59, MODE_UNUSED, 1'b1, 50);
    test_drain_pause();

    drain_pipeline();
    if (pending_displays.size() != 0) fault_count++;
    $display("Sent %0d words in stopwatch, countdown, clock and unused modes; %0d writes.",
             words_sent, reg_writes);
    $display("Checked %0d result words, %0d of them with the finished flag set.",
             displays_checked, finished_seen);
    if (fault_count == 0) begin
      $display("[stopwatch_countdown_hms_timer_core] OK");
    end else begin
      $display("[stopwatch_countdown_hms_timer_core] ERROR");
    end
    $finish;
  end

endmodule
